// ===== sv/ffba_pkg.sv =====
// Shared types and constants for the first-fit bump allocator.
package ffba_pkg;

  localparam int unsigned HEAP_SIZE_RESET = 32'd1048576;
  localparam int unsigned HDR_BYTES_RESET = 7'd8;

  typedef enum logic [1:0] {
    CFG_HEAP_BASE = 2'd0,
    CFG_HEAP_SIZE = 2'd1,
    CFG_HDR_BYTES = 2'd2,
    CFG_NONE      = 2'd3
  } ffba_cfg_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_NONE    = 2'd3
  } ffba_cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] pointer;
    logic [31:0] size;
    logic [31:0] header_word;
  } ffba_in_t;

  typedef struct packed {
    logic [31:0] result_pointer;
    logic        header_write;
    logic [31:0] header_address;
    logic [31:0] header_value;
    logic [31:0] clear_start;
    logic [31:0] clear_bytes;
    logic [31:0] copy_source;
    logic [31:0] copy_bytes;
    logic [31:0] used_bytes;
    logic        list_overflow;
  } ffba_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC,
    ST_A_RD,
    ST_A_CHK,
    ST_S_RD,
    ST_S_WR,
    ST_BUMP,
    ST_POST,
    ST_FREE,
    ST_F_RD,
    ST_F_CHK,
    ST_DONE
  } ffba_state_t;

  typedef struct packed {
    logic latch_in;
    logic clr_idx;
    logic inc_idx;
    logic rd_scan;
    logic rd_next;
    logic wr_shift;
    logic hit_out;
    logic dec_count;
    logic bump_out;
    logic fit_ptr;
    logic copy_out;
    logic append;
    logic set_ovf;
  } ffba_ctl_t;

  typedef struct packed {
    ffba_cmd_t cmd;
    logic      ptr_zero;
    logic      size_zero;
    logic      owns;
    logic      fits;
    logic      too_big;
    logic      idx_end;
    logic      next_end;
    logic      size_ok;
    logic      addr_match;
    logic      bump_fail;
    logic      hdr_small;
    logic      list_full;
    logic      moved_nz;
  } ffba_sts_t;

endpackage

// ===== sv/ffba_ctrl.sv =====
// Sequencer for request decode, list scans, list compaction and append.
module ffba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  input  ffba_pkg::ffba_sts_t sts,
  output ffba_pkg::ffba_ctl_t ctl
);
  import ffba_pkg::*;

  ffba_state_t state_r, state_nxt;
  logic        then_free_r, then_free_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      then_free_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      then_free_r <= then_free_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    then_free_nxt = then_free_r;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.latch_in  = 1'b1;
          then_free_nxt = 1'b0;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.cmd)
          CMD_ALLOC: state_nxt = ST_ALLOC;
          CMD_FREE:  state_nxt = ST_FREE;
          CMD_REALLOC: begin
            if (sts.ptr_zero) begin
              state_nxt = sts.size_zero ? ST_DONE : ST_ALLOC;
            end else if (sts.size_zero) begin
              state_nxt = ST_FREE;
            end else if (!sts.owns) begin
              state_nxt = ST_ALLOC;
            end else if (sts.fits) begin
              ctl.fit_ptr = 1'b1;
              state_nxt   = ST_DONE;
            end else begin
              then_free_nxt = 1'b1;
              state_nxt     = ST_ALLOC;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_ALLOC: begin
        if (sts.too_big) begin
          state_nxt = ST_DONE;
        end else begin
          ctl.clr_idx = 1'b1;
          state_nxt   = ST_A_RD;
        end
      end
      ST_A_RD: begin
        if (sts.idx_end) begin
          state_nxt = ST_BUMP;
        end else begin
          ctl.rd_scan = 1'b1;
          state_nxt   = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (sts.size_ok) begin
          ctl.hit_out = 1'b1;
          state_nxt   = ST_S_RD;
        end else begin
          ctl.inc_idx = 1'b1;
          state_nxt   = ST_A_RD;
        end
      end
      ST_S_RD: begin
        if (sts.next_end) begin
          ctl.dec_count = 1'b1;
          state_nxt     = ST_POST;
        end else begin
          ctl.rd_next = 1'b1;
          state_nxt   = ST_S_WR;
        end
      end
      ST_S_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.inc_idx  = 1'b1;
        state_nxt    = ST_S_RD;
      end
      ST_BUMP: begin
        if (sts.bump_fail) begin
          state_nxt = ST_DONE;
        end else begin
          ctl.bump_out = 1'b1;
          state_nxt    = ST_POST;
        end
      end
      ST_POST: begin
        if (then_free_r && sts.moved_nz) begin
          ctl.copy_out = 1'b1;
          state_nxt    = ST_FREE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FREE: begin
        if (!sts.owns || sts.hdr_small) begin
          state_nxt = ST_DONE;
        end else begin
          ctl.clr_idx = 1'b1;
          state_nxt   = ST_F_RD;
        end
      end
      ST_F_RD: begin
        if (sts.idx_end) begin
          if (sts.list_full) ctl.set_ovf = 1'b1;
          else ctl.append = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ctl.rd_scan = 1'b1;
          state_nxt   = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        if (sts.addr_match) begin
          state_nxt = ST_DONE;
        end else begin
          ctl.inc_idx = 1'b1;
          state_nxt   = ST_F_RD;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

// ===== sv/ffba_dp.sv =====
// Datapath: configuration, bump offset, free-list memory and result word.
module ffba_dp #(
  parameter int FREE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  ffba_pkg::ffba_in_t  in_data,
  output ffba_pkg::ffba_out_t out_data,
  input  ffba_pkg::ffba_ctl_t ctl,
  output ffba_pkg::ffba_sts_t sts
);
  import ffba_pkg::*;

  localparam int AW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int CW = $clog2(FREE_ENTRIES + 1);

  logic [31:0]   base_r, hsize_r, bump_r;
  logic [6:0]    hb_r;
  logic [CW-1:0] count_r, idx_r;
  ffba_in_t      in_r;
  ffba_out_t     out_r;
  logic [63:0]   mem [FREE_ENTRIES];
  logic [63:0]   rdata_r;

  logic [31:0] hb32, blk, old_pay, rd_addr, rd_size, hit_pay;
  logic [33:0] rnd, total;
  logic [32:0] own_lo, own_hi;
  logic [CW:0] idx_p1;
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [63:0]   wr_word;
  logic          wr_en;

  assign hb32    = {25'd0, hb_r};
  assign rnd     = ({2'b00, in_r.size} + 34'd7) & ~34'd7;
  assign total   = rnd + {27'd0, hb_r};
  assign own_lo  = {1'b0, base_r} + {26'd0, hb_r};
  assign own_hi  = {1'b0, base_r} + {1'b0, hsize_r};
  assign blk     = in_r.pointer - hb32;
  assign old_pay = (in_r.header_word < hb32) ? 32'd0 : in_r.header_word - hb32;
  assign rd_addr = rdata_r[63:32];
  assign rd_size = rdata_r[31:0];
  assign hit_pay = (rd_size - hb32) & ~32'd3;
  assign idx_p1  = {1'b0, idx_r} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    sts            = '0;
    sts.cmd        = ffba_cmd_t'(in_r.command);
    sts.ptr_zero   = (in_r.pointer == 32'd0);
    sts.size_zero  = (in_r.size == 32'd0);
    sts.owns       = ({1'b0, in_r.pointer} >= own_lo) && ({1'b0, in_r.pointer} < own_hi);
    sts.fits       = (old_pay >= in_r.size);
    sts.too_big    = (in_r.size > hsize_r);
    sts.idx_end    = (idx_r >= count_r);
    sts.next_end   = (idx_p1 >= {1'b0, count_r});
    sts.size_ok    = ({2'b00, rd_size} >= total);
    sts.addr_match = (rd_addr == blk);
    sts.bump_fail  = (({2'b00, bump_r} + total) > {2'b00, hsize_r});
    sts.hdr_small  = (in_r.header_word < hb32);
    sts.list_full  = (count_r >= CW'(FREE_ENTRIES));
    sts.moved_nz   = (out_r.result_pointer != 32'd0);
  end

  assign rd_ptr  = ctl.rd_next ? idx_p1[AW-1:0] : idx_r[AW-1:0];
  assign wr_en   = ctl.wr_shift || ctl.append;
  assign wr_ptr  = ctl.append ? count_r[AW-1:0] : idx_r[AW-1:0];
  assign wr_word = ctl.append ? {blk, in_r.header_word} : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_word;
    if (ctl.rd_scan || ctl.rd_next) rdata_r <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 32'd0;
      hsize_r <= HEAP_SIZE_RESET;
      hb_r    <= 7'(HDR_BYTES_RESET);
      bump_r  <= 32'd0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (ffba_cfg_t'(cfg_index))
          CFG_HEAP_BASE: base_r  <= cfg_data;
          CFG_HEAP_SIZE: hsize_r <= cfg_data;
          CFG_HDR_BYTES: hb_r    <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (ctl.clr_idx) idx_r <= '0;
      else if (ctl.inc_idx) idx_r <= idx_p1[CW-1:0];
      if (ctl.dec_count) count_r <= count_r - {{(CW-1){1'b0}}, 1'b1};
      else if (ctl.append) count_r <= count_r + {{(CW-1){1'b0}}, 1'b1};
      if (ctl.bump_out) bump_r <= bump_r + total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      in_r  <= in_data;
      out_r <= '0;
    end
    if (ctl.fit_ptr) out_r.result_pointer <= in_r.pointer;
    if (ctl.hit_out) begin
      out_r.header_write   <= 1'b1;
      out_r.header_address <= rd_addr;
      out_r.header_value   <= rd_size;
      out_r.result_pointer <= rd_addr + hb32;
      if (rd_size >= hb32 && hit_pay != 32'd0) begin
        out_r.clear_start <= rd_addr + hb32;
        out_r.clear_bytes <= hit_pay;
      end
    end
    if (ctl.bump_out) begin
      out_r.header_write   <= 1'b1;
      out_r.header_address <= base_r + bump_r;
      out_r.header_value   <= total[31:0];
      out_r.result_pointer <= base_r + bump_r + hb32;
    end
    if (ctl.copy_out && old_pay != 32'd0) begin
      out_r.copy_source <= in_r.pointer;
      out_r.copy_bytes  <= old_pay;
    end
    if (ctl.set_ovf) out_r.list_overflow <= 1'b1;
  end

  always_comb begin
    out_data            = out_r;
    out_data.used_bytes = bump_r;
  end

endmodule

// ===== sv/first_fit_bump_allocator.sv =====
// Top level of the first-fit bump allocator engine.
// Takes one request word when start is high and busy is low, and gives one result word
// with out_valid high for a single cycle; the receiver cannot stall it. The first-fit scan
// and the duplicate scan read the free list through the registered read port of the list
// memory, and removing an entry moves every later entry down by one.
// The list memory needs no clearing after reset.
module first_fit_bump_allocator #(
  parameter int FREE_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffba_pkg::ffba_in_t  in_data,
  output logic                out_valid,
  output ffba_pkg::ffba_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ffba_pkg::*;

  ffba_ctl_t ctl;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .sts(sts), .ctl(ctl)
  );

  ffba_dp #(.FREE_ENTRIES(FREE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_data(in_data), .out_data(out_data),
    .ctl(ctl), .sts(sts)
  );

endmodule

// ===== sv/ffba_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
module ffba_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input ffba_pkg::ffba_out_t out_data
);
  import ffba_pkg::*;

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result word held past one cycle");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_valid_busy: assert property (@(posedge clk)
    out_valid |-> busy) else $error("result word while idle");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (!busy && !out_valid)) else $error("busy after reset");

  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.header_write) |->
      (out_data.header_address == 32'd0 && out_data.header_value == 32'd0))
    else $error("header fields set without header write");

endmodule

bind first_fit_bump_allocator ffba_checker u_ffba_checker (.*);
